### sv/assert_macros.svh
// Assertion macros used by the RTL of the filter.
// Under synthesis every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed: property does not hold");

// The condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### sv/mcfir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mcfir_pkg;

	// Fixed field and arithmetic widths.
	localparam int SAMPLE_W      = 16;
	localparam int FRAC_W        = SAMPLE_W - 1;
	localparam int ACC_W         = 40;
	localparam int COEF_INDEX_W  = 6;
	localparam int CHANNEL_OUT_W = 3;
	localparam int TAP_COUNT_W   = 7;
	localparam int CHAN_COUNT_W  = 4;

	// Stream and configuration port widths.
	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 24;
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 7;

	// Default sizes.
	localparam int DEF_MAX_TAPS     = 64;
	localparam int DEF_MAX_CHANNELS = 8;

	// Item kinds carried on the input tuser.
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_COEF   = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] REG_TAP_COUNT     = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_COUNT = 1'b1;

	// Register reset values.
	localparam logic [TAP_COUNT_W-1:0]  TAP_COUNT_RST  = 7'd64;
	localparam logic [CHAN_COUNT_W-1:0] CHAN_COUNT_RST = 4'd1;

endpackage

`default_nettype wire

### sv/multichannel_fir_filter.sv
`timescale 1ns / 1ps
// Interleaved multichannel FIR filter with one shared multiply-accumulate unit.
// A coefficient write is taken in idle and leaves the block idle. An accepted sample is
// followed by tap walk, drain and rounding; no new item is taken until its result is registered.
// The rate is set by the single coefficient/history read port pair: one tap per cycle.
// After reset a clearing pass over MAX_CHANNELS * MAX_TAPS entries (512 by default) zeroes both
// memories; no item is accepted meanwhile, configuration writes are taken as usual.
`default_nettype none

`include "assert_macros.svh"

module multichannel_fir_filter #(
	parameter int MAX_TAPS     = mcfir_pkg::DEF_MAX_TAPS,
	parameter int MAX_CHANNELS = mcfir_pkg::DEF_MAX_CHANNELS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Input stream.
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// Fields from bit 0: sample[15:0], coef_index[21:16], coef_value[37:22], zero pad.
	input  wire logic [mcfir_pkg::S_TDATA_W-1:0]   s_tdata,
	// Fields: func[0].
	input  wire logic                              s_tuser,
	// Output stream.
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// Fields from bit 0: filtered[15:0], out_channel[18:16], zero pad.
	output logic [mcfir_pkg::M_TDATA_W-1:0]        m_tdata,
	// Fields: clipped[0].
	output logic                                   m_tuser,
	// Configuration write port.
	input  wire logic                              cfg_we,
	input  wire logic [mcfir_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [mcfir_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import mcfir_pkg::*;

	localparam int HIST_DEPTH = MAX_CHANNELS * MAX_TAPS;
	localparam int PTR_W      = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int HA_W       = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int TAP_W      = $clog2(MAX_TAPS + 1);
	localparam int CNT_W      = $clog2(MAX_CHANNELS + 1);
	localparam int RND_W      = ACC_W + 1 - FRAC_W;

	// Sequencer states.
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_MAC   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_ROUND = 3'd4;

	// Memories.
	logic signed [SAMPLE_W-1:0] coef_mem [MAX_TAPS];
	logic signed [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];

	// Control state.
	logic [2:0]              state_q;
	logic [HA_W-1:0]         clr_q;
	logic [TAP_COUNT_W-1:0]  tap_count_q;
	logic [CHAN_COUNT_W-1:0] chan_count_q;
	logic [CH_W-1:0]         chan_ctr_q;
	logic [PTR_W-1:0]        hp_q [MAX_CHANNELS];
	logic [TAP_W-1:0]        taps_q;
	logic [PTR_W-1:0]        k_q;
	logic [PTR_W-1:0]        pos_q;
	logic [HA_W-1:0]         base_q;
	logic [CH_W-1:0]         ch_q;
	logic                    vld_s1;
	logic                    vld_s2;

	// Datapath registers.
	logic signed [SAMPLE_W-1:0]   coef_rd_s1;
	logic signed [SAMPLE_W-1:0]   hist_rd_s1;
	logic signed [2*SAMPLE_W-1:0] prod_s2;
	logic [ACC_W-1:0]             acc_q;
	logic                         m_tvalid_q;
	logic [SAMPLE_W-1:0]          filtered_q;
	logic [CHANNEL_OUT_W-1:0]     out_ch_q;
	logic                         clip_q;

	// Input fields.
	logic                    in_func;
	logic [SAMPLE_W-1:0]     in_sample;
	logic [COEF_INDEX_W-1:0] in_coef_index;
	logic [SAMPLE_W-1:0]     in_coef_value;

	assign in_func       = s_tuser;
	assign in_sample     = s_tdata[SAMPLE_W-1:0];
	assign in_coef_index = s_tdata[SAMPLE_W +: COEF_INDEX_W];
	assign in_coef_value = s_tdata[SAMPLE_W+COEF_INDEX_W +: SAMPLE_W];

	// Handshake decode.
	logic in_fire;
	logic samp_fire;
	logic coef_fire;
	logic out_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign samp_fire = in_fire && (in_func == FUNC_SAMPLE);
	assign coef_fire = in_fire && (in_func == FUNC_COEF);
	assign out_free  = !m_tvalid_q || m_tready;

	// Effective tap and channel counts with out-of-range values clamped.
	logic [TAP_W-1:0] taps_eff;
	logic [CNT_W-1:0] chans_eff;

	always_comb begin
		if (tap_count_q == '0) begin
			taps_eff = TAP_W'(1);
		end else if (32'(tap_count_q) > MAX_TAPS) begin
			taps_eff = TAP_W'(MAX_TAPS);
		end else begin
			taps_eff = TAP_W'(tap_count_q);
		end
		if (chan_count_q == '0) begin
			chans_eff = CNT_W'(1);
		end else if (32'(chan_count_q) > MAX_CHANNELS) begin
			chans_eff = CNT_W'(MAX_CHANNELS);
		end else begin
			chans_eff = CNT_W'(chan_count_q);
		end
	end

	// Channel of the incoming sample, its history slot and the next channel.
	logic [CH_W-1:0]  ch_sel;
	logic [CH_W-1:0]  ch_next;
	logic [PTR_W-1:0] ptr_sel;
	logic [PTR_W-1:0] ptr_next;
	logic [HA_W-1:0]  base_sel;

	always_comb begin
		ch_sel   = (32'(chan_ctr_q) >= 32'(chans_eff)) ? '0 : chan_ctr_q;
		ch_next  = (32'(ch_sel) + 1 >= 32'(chans_eff)) ? '0 : CH_W'(32'(ch_sel) + 1);
		ptr_sel  = hp_q[ch_sel];
		ptr_next = (32'(ptr_sel) == MAX_TAPS - 1) ? '0 : PTR_W'(32'(ptr_sel) + 1);
		base_sel = HA_W'(ch_sel) * HA_W'(MAX_TAPS);
	end

	// Coefficient memory: cleared after reset, loaded by coefficient transactions.
	logic coef_idx_ok;
	assign coef_idx_ok = (32'(in_coef_index) < MAX_TAPS);

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			if (32'(clr_q) < MAX_TAPS) begin
				coef_mem[PTR_W'(clr_q)] <= '0;
			end
		end else if (coef_fire && coef_idx_ok) begin
			coef_mem[PTR_W'(in_coef_index)] <= in_coef_value;
		end
		coef_rd_s1 <= coef_mem[k_q];
	end

	// History memory: the new sample is written on acceptance, then read back tap by tap.
	logic [HA_W-1:0] hist_raddr;
	assign hist_raddr = base_q + HA_W'(pos_q);

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			hist_mem[clr_q] <= '0;
		end else if (samp_fire) begin
			hist_mem[base_sel + HA_W'(ptr_sel)] <= in_sample;
		end
		hist_rd_s1 <= hist_mem[hist_raddr];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q  <= TAP_COUNT_RST;
			chan_count_q <= CHAN_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_TAP_COUNT: begin
					tap_count_q <= cfg_wdata[TAP_COUNT_W-1:0];
				end
				REG_CHANNEL_COUNT: begin
					chan_count_q <= cfg_wdata[CHAN_COUNT_W-1:0];
				end
			endcase
		end
	end

	// Per-channel history pointers and the channel counter advance on each sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_ctr_q <= '0;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				hp_q[i] <= '0;
			end
		end else if (samp_fire) begin
			chan_ctr_q     <= ch_next;
			hp_q[ch_sel]   <= ptr_next;
		end
	end

	// Sequencer: clearing pass, idle, tap walk, pipeline drain, rounding.
	logic last_tap;
	assign last_tap = (TAP_W'(k_q) + TAP_W'(1) == taps_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			k_q     <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_MAC);
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + HA_W'(1);
					if (32'(clr_q) == HIST_DEPTH - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					k_q <= '0;
					if (samp_fire) begin
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					k_q <= k_q + PTR_W'(1);
					if (last_tap) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!vld_s1 && !vld_s2) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item context latched on acceptance; the read position walks backward through the ring.
	always_ff @(posedge clk) begin
		if (samp_fire) begin
			taps_q <= taps_eff;
			ch_q   <= ch_sel;
			base_q <= base_sel;
			pos_q  <= ptr_sel;
		end else if (state_q == ST_MAC) begin
			pos_q <= (pos_q == '0) ? PTR_W'(MAX_TAPS - 1) : pos_q - PTR_W'(1);
		end
	end

	// Multiply stage and accumulator.
	logic signed [ACC_W-1:0] prod_ext;
	assign prod_ext = ACC_W'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= coef_rd_s1 * hist_rd_s1;
		if (samp_fire) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + prod_ext;
		end
	end

	// Round to nearest with ties upward, then saturate to the sample range.
	logic [ACC_W:0]           acc_bias;
	logic [RND_W-1:0]         rnd;
	logic                     sat;
	logic [SAMPLE_W-1:0]      filt_val;

	always_comb begin
		acc_bias = {acc_q[ACC_W-1], acc_q} + ((ACC_W + 1)'(1) << (FRAC_W - 1));
		rnd      = acc_bias[ACC_W:FRAC_W];
		sat      = !((rnd[RND_W-1:SAMPLE_W-1] == '0) || (rnd[RND_W-1:SAMPLE_W-1] == '1));
		if (sat) begin
			filt_val = rnd[RND_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
			                        : {1'b0, {(SAMPLE_W-1){1'b1}}};
		end else begin
			filt_val = rnd[SAMPLE_W-1:0];
		end
	end

	// Output register holds the result until the downstream transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_ROUND) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_ROUND) && out_free) begin
			filtered_q <= filt_val;
			out_ch_q   <= CHANNEL_OUT_W'(ch_q);
			clip_q     <= sat;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'({out_ch_q, filtered_q});
	assign m_tuser  = clip_q;

	// Checks on the sequencer and the multiply-accumulate pipeline.
	`ASSERT_HOLDS(a_tap_in_range, clk, arst_n, (state_q == ST_MAC) |-> (TAP_W'(k_q) < taps_q))
	`ASSERT_HOLDS(a_round_drained, clk, arst_n, (state_q == ST_ROUND) |-> (!vld_s1 && !vld_s2))
	`ASSERT_HOLDS(a_busy_after_sample, clk, arst_n, samp_fire |=> !s_tready)
	`ASSERT_NEVER(a_no_output_in_clear, clk, arst_n, (state_q == ST_CLEAR) && m_tvalid)

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import mcfir_pkg::*;

	localparam int HALF_PERIOD    = 4;
	localparam int RESET_CYCLES   = 8;
	localparam int IDLE_PCT       = 23;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAPS           = DEF_MAX_TAPS;
	localparam int CHANNELS       = DEF_MAX_CHANNELS;

	// One input transaction, in field order.
	typedef struct packed {
		logic                          func;
		logic signed [SAMPLE_W-1:0]    sample;
		logic [COEF_INDEX_W-1:0]       coef_index;
		logic signed [SAMPLE_W-1:0]    coef_value;
	} fir_item_t;

	// One output transaction.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0]    filtered;
		logic [CHANNEL_OUT_W-1:0]      channel;
		logic                          clipped;
	} fir_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Items waiting to be sent and filter outputs still due.
	fir_item_t input_items[$];
	fir_out_t  expected_out[$];

	// Shadow copy of the filter state.
	logic signed [SAMPLE_W-1:0]  coef_mem[TAPS];
	logic signed [SAMPLE_W-1:0]  history[CHANNELS][TAPS];
	logic [COEF_INDEX_W-1:0]     history_ptr[CHANNELS];
	int                          channel_ctr;
	logic [TAP_COUNT_W-1:0]      tap_count_reg;
	logic [CHAN_COUNT_W-1:0]     chan_count_reg;

	logic      no_idle = 1'b0;
	int        mismatches = 0;
	int        idle_cycles = 0;
	fir_item_t drive_item;
	fir_item_t seen_item;
	fir_out_t  due;

	multichannel_fir_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// Run one accepted transaction through the shadow filter.
	task automatic fir_step(input fir_item_t it);
		int taps;
		int chans;
		int ch;
		int ptr;
		longint prod;
		longint rounded;
		logic signed [ACC_W-1:0] acc;
		fir_out_t o;
		if (it.func == FUNC_COEF) begin
			coef_mem[it.coef_index] = it.coef_value;
			return;
		end
		taps = (tap_count_reg == 0) ? 1 : ((tap_count_reg > TAPS) ? TAPS : int'(tap_count_reg));
		chans = (chan_count_reg == 0) ? 1 :
			((chan_count_reg > CHANNELS) ? CHANNELS : int'(chan_count_reg));
		if (channel_ctr >= chans) begin
			channel_ctr = 0;
		end
		ch = channel_ctr;
		ptr = int'(history_ptr[ch]);
		history[ch][ptr] = it.sample;

		// Exact sum of Q2.30 products, wrapping in the accumulator width.
		acc = '0;
		for (int k = 0; k < taps; k++) begin
			prod = longint'(coef_mem[k]) * longint'(history[ch][(ptr + TAPS - k) % TAPS]);
			acc = acc + prod[ACC_W-1:0];
		end

		// Round to nearest with ties upward, then saturate.
		rounded = (longint'(acc) + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
		o.clipped = 1'b0;
		if (rounded > 32767) begin
			rounded = 32767;
			o.clipped = 1'b1;
		end else if (rounded < -32768) begin
			rounded = -32768;
			o.clipped = 1'b1;
		end
		o.filtered = rounded[SAMPLE_W-1:0];
		o.channel = ch[CHANNEL_OUT_W-1:0];
		expected_out.push_back(o);

		history_ptr[ch] = history_ptr[ch] + 1'b1;
		channel_ctr = (ch + 1 >= chans) ? 0 : ch + 1;
	endtask

	// Q1.15 value with the extremes drawn more often than chance would.
	function automatic logic signed [SAMPLE_W-1:0] rand_q15();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'(int'($urandom_range(2)) - 1);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic fir_item_t sample_item(input logic signed [SAMPLE_W-1:0] v);
		fir_item_t it;
		it.func = FUNC_SAMPLE;
		it.sample = v;
		it.coef_index = 6'($urandom);
		it.coef_value = 16'($urandom);
		return it;
	endfunction

	function automatic fir_item_t coef_item(input int idx, input logic signed [SAMPLE_W-1:0] v);
		fir_item_t it;
		it.func = FUNC_COEF;
		it.sample = 16'($urandom);
		it.coef_index = idx[COEF_INDEX_W-1:0];
		it.coef_value = v;
		return it;
	endfunction

	// Mostly samples, with coefficient updates sprinkled in.
	function automatic fir_item_t rand_item();
		if ($urandom_range(99) < 15) begin
			return coef_item($urandom_range(TAPS - 1), rand_q15());
		end
		return sample_item(rand_q15());
	endfunction

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold off until everything sent has been filtered and the block is idle.
	task automatic drain();
		do begin
			@(negedge clk);
		end while (input_items.size() != 0 || s_tvalid || expected_out.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic push_random(input int count);
		@(negedge clk);
		for (int i = 0; i < count; i++) begin
			input_items.push_back(rand_item());
		end
	endtask

	// Sender: offers the next queued transaction once the current one is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_tready) begin
				if (input_items.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
					drive_item = input_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {2'b00, drive_item.coef_value, drive_item.coef_index,
						drive_item.sample};
					s_tuser <= drive_item.func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver backpressure.
	always @(posedge clk) begin
		if (arst_n) begin
			m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Monitor: checks outputs, predicts from accepted inputs, tracks registers.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_out.size() == 0) begin
					$error("output with nothing due: filtered %0d channel %0d",
						$signed(m_tdata[15:0]), m_tdata[18:16]);
					mismatches++;
				end else begin
					due = expected_out.pop_front();
					if (m_tdata[15:0] !== due.filtered) begin
						$error("filtered: expected %0d, actual %0d",
							due.filtered, $signed(m_tdata[15:0]));
						mismatches++;
					end
					if (m_tdata[18:16] !== due.channel) begin
						$error("out_channel: expected %0d, actual %0d",
							due.channel, m_tdata[18:16]);
						mismatches++;
					end
					if (m_tuser !== due.clipped) begin
						$error("clipped: expected %0d, actual %0d", due.clipped, m_tuser);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				seen_item.func = s_tuser;
				seen_item.sample = s_tdata[15:0];
				seen_item.coef_index = s_tdata[21:16];
				seen_item.coef_value = s_tdata[37:22];
				fir_step(seen_item);
			end
			if (cfg_we) begin
				if (cfg_addr == REG_TAP_COUNT) begin
					tap_count_reg = cfg_wdata[TAP_COUNT_W-1:0];
				end else if (cfg_addr == REG_CHANNEL_COUNT) begin
					chan_count_reg = cfg_wdata[CHAN_COUNT_W-1:0];
				end
			end

			// Watchdog on cycles without any transaction.
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || cfg_we) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Test sequence.
	initial begin
		for (int c = 0; c < CHANNELS; c++) begin
			history_ptr[c] = '0;
			for (int t = 0; t < TAPS; t++) begin
				history[c][t] = '0;
			end
		end
		for (int t = 0; t < TAPS; t++) begin
			coef_mem[t] = '0;
		end
		channel_ctr = 0;
		tap_count_reg = TAP_COUNT_RST;
		chan_count_reg = CHAN_COUNT_RST;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, rounding ties and saturation on two taps.
		write_reg(REG_TAP_COUNT, 2);
		write_reg(REG_CHANNEL_COUNT, 1);
		@(negedge clk);
		input_items.push_back(coef_item(0, -16'sd32768));
		input_items.push_back(coef_item(1, -16'sd32768));
		input_items.push_back(coef_item(TAPS - 1, 16'sd32767));
		input_items.push_back(sample_item(-16'sd32768));
		input_items.push_back(sample_item(-16'sd32768));
		input_items.push_back(sample_item(16'sd32767));
		input_items.push_back(sample_item(16'sd0));
		input_items.push_back(sample_item(16'sd1));
		input_items.push_back(sample_item(-16'sd1));
		input_items.push_back(coef_item(0, 16'sd1));
		input_items.push_back(coef_item(1, 16'sd0));
		input_items.push_back(sample_item(16'sd16384));
		input_items.push_back(sample_item(-16'sd16384));
		input_items.push_back(coef_item(0, 16'sd32767));
		input_items.push_back(coef_item(1, 16'sd32767));
		input_items.push_back(sample_item(16'sd32767));
		input_items.push_back(sample_item(16'sd32767));
		input_items.push_back(coef_item(0, -16'sd32768));
		input_items.push_back(coef_item(1, -16'sd32768));
		input_items.push_back(sample_item(16'sd32767));
		input_items.push_back(sample_item(16'sd32767));
		drain();

		// Zero in both registers acts as one.
		write_reg(REG_TAP_COUNT, 0);
		write_reg(REG_CHANNEL_COUNT, 0);
		push_random(30);
		drain();

		// Lower the channel count while the counter sits beyond it.
		write_reg(REG_TAP_COUNT, TAPS);
		write_reg(REG_CHANNEL_COUNT, CHANNELS);
		@(negedge clk);
		for (int i = 0; i < 6; i++) begin
			input_items.push_back(sample_item(rand_q15()));
		end
		drain();
		write_reg(REG_CHANNEL_COUNT, 3);
		write_reg(REG_TAP_COUNT, 127);
		push_random(100);
		drain();

		// Full size with no idling on either side.
		write_reg(REG_TAP_COUNT, TAPS);
		write_reg(REG_CHANNEL_COUNT, CHANNELS);
		@(negedge clk);
		no_idle = 1'b1;
		push_random(120);
		drain();
		no_idle = 1'b0;

		// Single tap, channel count above the maximum.
		write_reg(REG_TAP_COUNT, 1);
		write_reg(REG_CHANNEL_COUNT, 15);
		push_random(100);
		drain();

		// Random legal settings.
		for (int p = 0; p < 5; p++) begin
			write_reg(REG_TAP_COUNT, $urandom_range(1, TAPS));
			write_reg(REG_CHANNEL_COUNT, $urandom_range(1, CHANNELS));
			push_random(90);
			drain();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && expected_out.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/mcfir_pkg.sv
sv/multichannel_fir_filter.sv
sim/tb_top.sv
